// ----- hdl/hcbd_pkg.sv -----
// ----------------------------------------------------------------------------
// hcbd_pkg
// shared codes, character constants and the hex digit decoder of the
// chunked body decoder
// ----------------------------------------------------------------------------
package hcbd_pkg;

  // result status codes
  localparam logic [1:0] ST_PAYLOAD  = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_ERROR    = 2'd2;

  // error kinds
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_BAD_LINE   = 2'd1;
  localparam logic [1:0] ERR_SIZE_OVF   = 2'd2;
  localparam logic [1:0] ERR_OVER_LIMIT = 2'd3;

  // characters of the size line
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  // widest chunk size in hex digits
  localparam int SIZE_HEX_DIGITS = 8;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c inside {[8'h30 : 8'h39]}) begin
      h.val = 4'(c - 8'h30);
    end else if (c inside {[8'h41 : 8'h46]}) begin
      h.val = 4'(c - 8'h41 + 8'd10);
    end else if (c inside {[8'h61 : 8'h66]}) begin
      h.val = 4'(c - 8'h61 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ----- hdl/http_chunked_body_decoder.sv -----
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// decodes an http/1.1 chunked transfer body, one byte per word
// ----------------------------------------------------------------------------
// Feed the body bytes that follow the response header, one per input word.
// For every payload byte the block returns one word with status 0 and the
// running count of payload bytes; size lines and the two bytes after each
// chunk give no word. A zero-size chunk (or a size line with no digits) gives
// one status 1 word, a malformed size line, a size with more significant hex
// digits than MAX_SIZE_DIGITS (capped at 8) or a declared total above
// max_body_length (0 = no limit) gives one status 2 word with its error kind.
// After either of those the block swallows every byte silently until reset.
// Throughput is one byte per clock while results are taken; each byte is
// held in the input register, then moves on to the output registers once
// those are free or draining. The input side stays ready while a result
// waits only if that register is empty. The user must write max_body_length
// through cfg_write_en / cfg_wdata while the block is idle; not enforced.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder #(
  parameter int MAX_SIZE_DIGITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write_en,
  input  logic [31:0] cfg_wdata,
  // body bytes in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  // results out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  status,
  output logic [1:0]  error_kind,
  output logic [31:0] bytes_delivered
);
  import hcbd_pkg::*;

  // significant digits allowed, never more than the size register holds
  localparam int DigitLim = (MAX_SIZE_DIGITS < SIZE_HEX_DIGITS) ?
                            MAX_SIZE_DIGITS : SIZE_HEX_DIGITS;
  localparam int SdW      = $clog2(DigitLim + 1);

  typedef enum logic [2:0] {
    PH_SIZE_START,
    PH_DIGITS,
    PH_EXT,
    PH_CR_SEEN,
    PH_DATA,
    PH_TRAIL1,
    PH_TRAIL2,
    PH_DONE
  } phase_t;

  // configuration register
  logic [31:0] max_body_length;

  // input register
  logic        byte_valid;
  logic [7:0]  byte_q;

  // decoder state
  phase_t         phase, phase_next;
  logic [31:0]    chunk_left, chunk_left_next;
  logic [31:0]    declared_total, declared_total_next;
  logic [SdW-1:0] size_digits, size_digits_next;
  logic [31:0]    delivered_count, delivered_count_next;

  // result of the byte in the input register
  logic        res_valid;
  logic [7:0]  res_byte;
  logic [1:0]  res_status;
  logic [1:0]  res_error;
  logic [31:0] res_count;

  logic        advance;
  hex_digit_t  hex;
  logic [32:0] sum;

  // the held byte moves on whenever the result register is free or draining
  assign advance  = byte_valid && (!out_valid || out_ready);
  // nothing is taken while reset holds the input register empty
  assign in_ready = !rst && (!byte_valid || advance);

  assign hex = hex_decode(byte_q);
  assign sum = {1'b0, declared_total} + {1'b0, chunk_left};

  always_comb begin
    phase_next           = phase;
    chunk_left_next      = chunk_left;
    declared_total_next  = declared_total;
    size_digits_next     = size_digits;
    delivered_count_next = delivered_count;
    res_valid            = 1'b0;
    res_byte             = 8'd0;
    res_status           = ST_PAYLOAD;
    res_error            = ERR_NONE;
    res_count            = delivered_count;

    case (phase)
      PH_SIZE_START, PH_DIGITS: begin
        if (hex.ok) begin
          // leading zeros are not counted as digits
          if ((chunk_left != 32'd0 || hex.val != 4'd0) &&
              size_digits >= SdW'(DigitLim)) begin
            phase_next = PH_DONE;
            res_valid  = 1'b1;
            res_status = ST_ERROR;
            res_error  = ERR_SIZE_OVF;
          end else begin
            if (chunk_left != 32'd0 || hex.val != 4'd0) begin
              size_digits_next = size_digits + SdW'(1);
            end
            chunk_left_next = {chunk_left[27:0], hex.val};
            phase_next      = PH_DIGITS;
          end
        end else if (byte_q == CHAR_SEMI) begin
          phase_next = PH_EXT;
        end else if (byte_q == CHAR_CR) begin
          phase_next = PH_CR_SEEN;
        end else begin
          phase_next = PH_DONE;
          res_valid  = 1'b1;
          res_status = ST_ERROR;
          res_error  = ERR_BAD_LINE;
        end
      end
      PH_EXT: begin
        if (byte_q == CHAR_CR) begin
          phase_next = PH_CR_SEEN;
        end
      end
      PH_CR_SEEN: begin
        if (byte_q == CHAR_LF) begin
          // end of size line: last chunk, limit check or start of data
          if (chunk_left == 32'd0) begin
            phase_next = PH_DONE;
            res_valid  = 1'b1;
            res_status = ST_COMPLETE;
          end else if (max_body_length != 32'd0 && sum > {1'b0, max_body_length}) begin
            phase_next = PH_DONE;
            res_valid  = 1'b1;
            res_status = ST_ERROR;
            res_error  = ERR_OVER_LIMIT;
          end else begin
            declared_total_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            phase_next          = PH_DATA;
          end
        end else if (byte_q != CHAR_CR) begin
          phase_next = PH_EXT;
        end
      end
      PH_DATA: begin
        delivered_count_next = delivered_count + 32'd1;
        chunk_left_next      = chunk_left - 32'd1;
        if (chunk_left == 32'd1) begin
          phase_next = PH_TRAIL1;
        end
        res_valid = 1'b1;
        res_byte  = byte_q;
        res_count = delivered_count + 32'd1;
      end
      PH_TRAIL1: begin
        phase_next = PH_TRAIL2;
      end
      PH_TRAIL2: begin
        phase_next       = PH_SIZE_START;
        chunk_left_next  = 32'd0;
        size_digits_next = '0;
      end
      default: begin
        // body finished or failed: swallow everything
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_length <= 32'd0;
      byte_valid      <= 1'b0;
      phase           <= PH_SIZE_START;
      chunk_left      <= 32'd0;
      declared_total  <= 32'd0;
      size_digits     <= '0;
      delivered_count <= 32'd0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        max_body_length <= cfg_wdata;
      end
      if (in_ready) begin
        byte_valid <= in_valid;
      end
      if (advance) begin
        phase           <= phase_next;
        chunk_left      <= chunk_left_next;
        declared_total  <= declared_total_next;
        size_digits     <= size_digits_next;
        delivered_count <= delivered_count_next;
        out_valid       <= res_valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= in_byte;
    end
    if (advance && res_valid) begin
      out_byte        <= res_byte;
      status          <= res_status;
      error_kind      <= res_error;
      bytes_delivered <= res_count;
    end
  end

  // a data phase always has bytes left to pass
  a_data_has_bytes: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> chunk_left != 32'd0)
    else $error("data phase with empty chunk");

  // digit count never passes its cap
  a_digit_cap: assert property (@(posedge clk) disable iff (rst)
    size_digits <= SdW'(DigitLim))
    else $error("size digit count beyond cap");

  // error kind goes with error status only
  a_error_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((status == ST_ERROR) == (error_kind != ERR_NONE)))
    else $error("error kind does not match status");

  // once finished, a drained result is never followed by another
  a_silent_after_end: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE && out_valid && out_ready) |=> !out_valid)
    else $error("result after body end");

  // a held byte is always processed once the output side frees up
  a_byte_moves: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && !out_valid) |=> (!byte_valid || $past(in_valid && in_ready)))
    else $error("input byte stuck with free output");

endmodule
